// ===== rtl/lcsmb_pkg.sv =====
package lcsmb_pkg;

    localparam int MAX_LEN    = 16;
    localparam int MAX_BUDGET = 15;

    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int BUD_W     = (MAX_BUDGET > 0) ? $clog2(MAX_BUDGET + 1) : 1;
    localparam int SCORE_W   = CNT_W;
    localparam int ROW_AW    = IDX_W + BUD_W;
    localparam int ROW_DEPTH = 2 ** ROW_AW;

    localparam int SYM_W     = 8;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 4;
    localparam int OUT_LEN_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic   same;
        logic   has_budget;
        score_t up;
        score_t left;
        score_t diag;
        score_t diag_less;
    } cell_in_t;

    function automatic logic [OUT_LEN_W-1:0] sat_len(input score_t v);
        if (32'(v) > (2 ** OUT_LEN_W - 1)) begin
            return '1;
        end
        return OUT_LEN_W'(v);
    endfunction

endpackage

// ===== rtl/lcs_with_mismatch_budget.sv =====
// LCS with a mismatch budget.
// Input channel s_*: s_tuser carries the operation (append to the first string,
// append to the second string, compute); s_tdata carries the symbol. Appends
// give no result; an append to a full string is dropped and sets the
// truncation flag. Operation 3 is taken and ignored.
// A compute item walks the table one cell at a time through one shared cell
// unit and a row memory (read step, then compute/write step); s_tready is
// low during that walk. With an empty string, compute skips the walk. The
// result (m_tdata: match length, m_tuser: truncated) sits in an output
// register; appends are taken while it waits for m_tready, a new compute
// finishes its walk and then holds until the register is free.
// Compute clears both strings and the truncation flag.
// cfg_wr_en/cfg_wr_data write the budget at any edge; use it only when idle.
// Reset (aresetn low, synchronous) empties both strings, clears the flag,
// sets the budget to 0 and drops any pending result.
module lcs_with_mismatch_budget (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lcsmb_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] symbol
    input  logic [1:0]                     s_tuser,   // [1:0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [4:0] match_length, [7:5] zero
    output logic [0:0]                     m_tuser    // [0] truncated
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CALC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int IDX_W = lcsmb_pkg::IDX_W;
    localparam int CNT_W = lcsmb_pkg::CNT_W;
    localparam int BUD_W = lcsmb_pkg::BUD_W;

    state_t state_reg, state_next;

    logic [lcsmb_pkg::CFG_W-1:0]     budget_reg;
    logic [CNT_W-1:0]                len_a_reg, len_b_reg;
    logic                            ovf_reg;
    logic [lcsmb_pkg::SYM_W-1:0]     str_a_reg [lcsmb_pkg::MAX_LEN];
    logic [lcsmb_pkg::SYM_W-1:0]     str_b_reg [lcsmb_pkg::MAX_LEN];

    logic [CNT_W-1:0]                n_a_reg, n_b_reg;
    logic                            trunc_reg;
    logic [BUD_W-1:0]                bud_eff_reg;
    logic [IDX_W-1:0]                i_reg, j_reg;
    logic [BUD_W-1:0]                k_reg;

    lcsmb_pkg::score_t               row_mem [lcsmb_pkg::ROW_DEPTH];
    lcsmb_pkg::score_t               rd_reg;
    lcsmb_pkg::score_t               old_line_reg [lcsmb_pkg::MAX_BUDGET + 1];
    lcsmb_pkg::score_t               new_line_reg [lcsmb_pkg::MAX_BUDGET + 1];
    lcsmb_pkg::score_t               diag_reg;
    lcsmb_pkg::score_t               ans_reg;

    logic                              m_valid_reg;
    logic [lcsmb_pkg::OUT_LEN_W-1:0]   m_len_reg;
    logic                              m_trunc_reg;

    logic                        in_fire, out_fire, load_out;
    logic                        is_compute, empty_in;
    logic                        last_i, last_j, last_k, ans_cell;
    logic [lcsmb_pkg::ROW_AW-1:0] row_addr;
    lcsmb_pkg::score_t           old_val;
    lcsmb_pkg::score_t           cell_score;
    lcsmb_pkg::cell_in_t         cell_in;
    logic [BUD_W-1:0]            bud_clamped;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_valid_reg && m_tready;
    assign load_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign is_compute = (s_tuser == lcsmb_pkg::OP_COMPUTE);
    assign empty_in   = (len_a_reg == '0) || (len_b_reg == '0);

    assign last_i   = (CNT_W'(i_reg) + CNT_W'(1)) == n_a_reg;
    assign last_j   = (CNT_W'(j_reg) + CNT_W'(1)) == n_b_reg;
    assign last_k   = (k_reg == BUD_W'(lcsmb_pkg::MAX_BUDGET));
    assign ans_cell = last_i && last_j && (k_reg == bud_eff_reg);
    assign row_addr = {j_reg, k_reg};
    assign old_val  = (i_reg == '0) ? '0 : rd_reg;

    assign bud_clamped = (32'(budget_reg) > lcsmb_pkg::MAX_BUDGET) ?
                         BUD_W'(lcsmb_pkg::MAX_BUDGET) : BUD_W'(budget_reg);

    always_comb begin
        cell_in.same       = (str_a_reg[i_reg] == str_b_reg[j_reg]);
        cell_in.has_budget = (k_reg != '0);
        cell_in.up         = old_val;
        cell_in.left       = new_line_reg[0];
        cell_in.diag       = old_line_reg[0];
        cell_in.diag_less  = diag_reg;
    end

    lcsmb_cell u_cell (
        .cell_in (cell_in),
        .score   (cell_score)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && is_compute) begin
                    state_next = empty_in ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ans_cell ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            budget_reg  <= '0;
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                case (s_tuser)
                    lcsmb_pkg::OP_APPEND_FIRST: begin
                        if (32'(len_a_reg) < lcsmb_pkg::MAX_LEN) begin
                            len_a_reg <= len_a_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    lcsmb_pkg::OP_APPEND_SECOND: begin
                        if (32'(len_b_reg) < lcsmb_pkg::MAX_LEN) begin
                            len_b_reg <= len_b_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    lcsmb_pkg::OP_COMPUTE: begin
                        len_a_reg <= '0;
                        len_b_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (out_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (s_tuser == lcsmb_pkg::OP_APPEND_FIRST)
            && (32'(len_a_reg) < lcsmb_pkg::MAX_LEN)) begin
            str_a_reg[len_a_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (in_fire && (s_tuser == lcsmb_pkg::OP_APPEND_SECOND)
            && (32'(len_b_reg) < lcsmb_pkg::MAX_LEN)) begin
            str_b_reg[len_b_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    // table walk: i rows, j columns, k budget levels
    always_ff @(posedge aclk) begin
        if (in_fire && is_compute) begin
            n_a_reg     <= len_a_reg;
            n_b_reg     <= len_b_reg;
            trunc_reg   <= ovf_reg;
            bud_eff_reg <= bud_clamped;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            ans_reg     <= '0;
            for (int n = 0; n <= lcsmb_pkg::MAX_BUDGET; n++) begin
                old_line_reg[n] <= '0;
                new_line_reg[n] <= '0;
            end
        end else if (state_reg == ST_CALC) begin
            diag_reg <= old_line_reg[0];
            if (ans_cell) begin
                ans_reg <= cell_score;
            end
            if (last_k) begin
                k_reg <= '0;
                if (last_j) begin
                    j_reg <= '0;
                    i_reg <= i_reg + IDX_W'(1);
                end else begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end else begin
                k_reg <= k_reg + BUD_W'(1);
            end
            if (last_k && last_j) begin
                for (int n = 0; n <= lcsmb_pkg::MAX_BUDGET; n++) begin
                    old_line_reg[n] <= '0;
                    new_line_reg[n] <= '0;
                end
            end else begin
                for (int n = 0; n < lcsmb_pkg::MAX_BUDGET; n++) begin
                    old_line_reg[n] <= old_line_reg[n+1];
                    new_line_reg[n] <= new_line_reg[n+1];
                end
                old_line_reg[lcsmb_pkg::MAX_BUDGET] <= old_val;
                new_line_reg[lcsmb_pkg::MAX_BUDGET] <= cell_score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_reg <= row_mem[row_addr];
        end
        if (state_reg == ST_CALC) begin
            row_mem[row_addr] <= cell_score;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_len_reg   <= lcsmb_pkg::sat_len(ans_reg);
            m_trunc_reg <= trunc_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{(8 - lcsmb_pkg::OUT_LEN_W){1'b0}}, m_len_reg};
    assign m_tuser[0] = m_trunc_reg;

    a_cells_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |->
            (32'(i_reg) < 32'(n_a_reg)) && (32'(j_reg) < 32'(n_b_reg)))
        else $error("table walk outside loaded strings");

    a_result_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (32'(m_len_reg) <= 32'(n_a_reg)) && (32'(m_len_reg) <= 32'(n_b_reg)))
        else $error("match length exceeds a string length");

    a_compute_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_compute) |=> (len_a_reg == '0) && (len_b_reg == '0) && !ovf_reg)
        else $error("compute did not clear the strings");

endmodule

// ===== rtl/lcsmb_cell.sv =====
module lcsmb_cell (
    input  lcsmb_pkg::cell_in_t cell_in,
    output lcsmb_pkg::score_t   score
);

    lcsmb_pkg::score_t best;
    lcsmb_pkg::score_t spend;
    lcsmb_pkg::score_t hit;

    always_comb begin
        best  = (cell_in.up > cell_in.left) ? cell_in.up : cell_in.left;
        spend = lcsmb_pkg::score_t'(cell_in.diag_less + 1'b1);
        hit   = lcsmb_pkg::score_t'(cell_in.diag + 1'b1);
        if (cell_in.has_budget && (spend > best)) begin
            best = spend;
        end
        score = cell_in.same ? hit : best;
    end

endmodule
